FILE: src/pmwt_pkg.sv
// Shared widths, field layouts and codes for the point merge block.
package pmwt_pkg;

    localparam int COORD_W  = 32;   // signed Q16.16 coordinate
    localparam int TOL_W    = 31;   // unsigned Q15.16 tolerance
    localparam int ID_W     = 10;   // node id field
    localparam int TOTAL_W  = 32;   // merge counter
    localparam int AXES     = 3;
    localparam int S_DATA_W = AXES * COORD_W;     // px, py, pz
    localparam int M_DATA_W = 48;                 // node_id, merged_total, zero pad
    localparam int M_USER_W = 2;                  // merged, full_res
    localparam int SQ_W     = 2 * TOL_W;          // one squared distance term
    localparam int SUM_W    = SQ_W + 2;           // sum of three terms
    localparam int RANK_W   = 5;                  // 27 neighbour cells
    localparam int STEP_W   = 5;                  // remainder steps, one bit each

    // item kind on s_tuser
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef logic [COORD_W-1:0] coord_t;

endpackage

FILE: src/point_merge_within_tolerance.sv
// Point merge within tolerance: node table in block memory with a scanning pipeline.
//
// Each add item (s_tuser low) carries a point; the block scans every stored node once from
// a single-port-read memory, one node per cycle, and returns the id of the stored node
// within the Euclidean tolerance (first in cell order dx,dy,dz, then lowest id), or
// stores the point and returns its new id, or flags full_res when the table is full.
// Cells have edge twice the tolerance; the query's position inside its cell is found by a
// one-bit-per-cycle remainder unit. From its acceptance an add item runs through 32
// remainder steps, a floor-adjust step, one memory read per stored node, a drain of the
// three-stage compare pipeline and a finishing step; with a zero tolerance or an empty
// table an add item, and any clear item (s_tuser high), goes straight to the finishing
// step. A result still waiting on the m_ side holds the finishing step. Reads and the
// single write of an item never overlap, so no forwarding is needed. The next item is
// taken while the previous result still waits on the m_ side.
module point_merge_within_tolerance #(
    parameter int MAX_NODES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pmwt_pkg::TOL_W-1:0]        cfg_wdata,   // tolerance
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pmwt_pkg::S_DATA_W-1:0]     s_tdata,     // px, py, pz
    input  logic                              s_tuser,     // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pmwt_pkg::M_DATA_W-1:0]     m_tdata,     // node_id, merged_total, pad
    output logic [pmwt_pkg::M_USER_W-1:0]     m_tuser      // merged, full_res
);
    import pmwt_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_NODES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ADJ  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]            state_reg;
    logic [TOL_W-1:0]      tol_reg;
    logic [CW-1:0]         count_reg;
    logic [TOTAL_W-1:0]    merge_reg;
    logic [S_DATA_W-1:0]   q_reg;
    logic                  func_reg;
    logic [COORD_W-1:0]    rem_reg [AXES];
    logic [COORD_W-1:0]    mag_reg [AXES];
    logic [AXES-1:0]       neg_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [COORD_W-1:0]    cs_reg;
    logic [SQ_W-1:0]       tolsq_reg;
    logic [CW-1:0]         idx_reg;

    // node table
    logic [S_DATA_W-1:0]   mem [MAX_NODES];
    logic [S_DATA_W-1:0]   rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;

    // scan pipeline
    logic                  v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]         id1_reg, id2_reg, id3_reg;
    logic [TOL_W-1:0]      ax_reg [AXES];
    logic [AXES-1:0]       box_reg, om_reg, op_reg;
    logic [SQ_W-1:0]       sq_reg [AXES];
    logic                  box3_reg;
    logic [RANK_W-1:0]     rank3_reg;
    logic                  found_reg;
    logic [RANK_W-1:0]     best_rank_reg;
    logic [AW-1:0]         best_id_reg;

    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_USER_W-1:0]   m_user_reg;

    logic [COORD_W-1:0]    rem_next [AXES];
    logic [TOL_W-1:0]      ax_next  [AXES];
    logic [AXES-1:0]       box_next, om_next, op_next;
    logic [RANK_W-1:0]     rank_next;
    logic [SUM_W-1:0]      dist_sum;
    logic                  hit;
    logic                  scan_done;
    logic                  fin_go;
    logic [TOTAL_W-1:0]    merge_next;
    logic [ID_W-1:0]       cnt_id, best_id_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign rd_en     = (state_reg == ST_SCAN) && (idx_reg < count_reg);
    assign rd_addr   = idx_reg[AW-1:0];
    assign scan_done = (state_reg == ST_SCAN) && !rd_en && !v1_reg && !v2_reg && !v3_reg;
    assign fin_go    = (state_reg == ST_FIN) && (!m_valid_reg || m_tready);
    assign wr_en     = fin_go && (func_reg == FUNC_ADD) && !found_reg && (count_reg < FULL_CNT);
    assign merge_next = (merge_reg == TOTAL_MAX) ? merge_reg : merge_reg + 1'b1;
    assign cnt_id      = ID_W'(32'(count_reg));
    assign best_id_out = ID_W'(32'(best_id_reg));

    // remainder step and distance terms per axis
    always_comb begin
        logic [COORD_W:0]   trial;
        logic signed [33:0] d;
        logic [32:0]        ad;
        logic signed [33:0] t;
        logic [1:0]         o [AXES];
        for (int k = 0; k < AXES; k++) begin
            trial = {rem_reg[k], mag_reg[k][COORD_W-1]};
            if (trial >= {1'b0, cs_reg}) begin
                rem_next[k] = COORD_W'(trial - {1'b0, cs_reg});
            end else begin
                rem_next[k] = trial[COORD_W-1:0];
            end
            d = $signed({{2{rd_data_reg[k*COORD_W+COORD_W-1]}}, rd_data_reg[k*COORD_W +: COORD_W]})
              - $signed({{2{q_reg[k*COORD_W+COORD_W-1]}}, q_reg[k*COORD_W +: COORD_W]});
            ad = d[33] ? 33'(-d) : d[32:0];
            box_next[k] = (ad <= {2'b00, tol_reg});
            ax_next[k]  = ad[TOL_W-1:0];
            t = $signed({2'b00, rem_reg[k]}) + d;
            om_next[k] = t[33];
            op_next[k] = (t >= $signed({2'b00, cs_reg}));
        end
        for (int k = 0; k < AXES; k++) begin
            o[k] = om_reg[k] ? 2'd0 : (op_reg[k] ? 2'd2 : 2'd1);
        end
        rank_next = RANK_W'(o[0]) * RANK_W'(9) + RANK_W'(o[1]) * RANK_W'(3) + RANK_W'(o[2]);
    end

    assign dist_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    assign hit      = v3_reg && box3_reg && (dist_sum <= SUM_W'(tolsq_reg));

    // node memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= q_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // compare pipeline payload
    always_ff @(posedge aclk) begin
        id1_reg <= rd_addr;
        id2_reg <= id1_reg;
        id3_reg <= id2_reg;
        box_reg <= box_next;
        om_reg  <= om_next;
        op_reg  <= op_next;
        for (int k = 0; k < AXES; k++) begin
            ax_reg[k] <= ax_next[k];
            sq_reg[k] <= ax_reg[k] * ax_reg[k];
        end
        box3_reg  <= &box_reg;
        rank3_reg <= rank_next;
    end

    // sequencer, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tol_reg     <= '0;
            count_reg   <= '0;
            merge_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (m_valid_reg && m_tready && !fin_go) begin
                m_valid_reg <= 1'b0;
            end
            if (hit && (!found_reg || rank3_reg < best_rank_reg)) begin
                found_reg     <= 1'b1;
                best_rank_reg <= rank3_reg;
                best_id_reg   <= id3_reg;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        q_reg     <= s_tdata;
                        func_reg  <= s_tuser;
                        cs_reg    <= {tol_reg, 1'b0};
                        tolsq_reg <= tol_reg * tol_reg;
                        step_reg  <= '0;
                        found_reg <= 1'b0;
                        for (int k = 0; k < AXES; k++) begin
                            rem_reg[k] <= '0;
                            neg_reg[k] <= s_tdata[k*COORD_W+COORD_W-1];
                            mag_reg[k] <= s_tdata[k*COORD_W+COORD_W-1]
                                        ? COORD_W'(~s_tdata[k*COORD_W +: COORD_W] + 1'b1)
                                        : s_tdata[k*COORD_W +: COORD_W];
                        end
                        if (s_tuser == FUNC_CLEAR || tol_reg == '0 || count_reg == '0) begin
                            state_reg <= ST_FIN;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    for (int k = 0; k < AXES; k++) begin
                        rem_reg[k] <= rem_next[k];
                        mag_reg[k] <= {mag_reg[k][COORD_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(COORD_W - 1)) begin
                        state_reg <= ST_ADJ;
                    end
                end
                ST_ADJ: begin
                    // floor remainder for negative coordinates
                    for (int k = 0; k < AXES; k++) begin
                        if (neg_reg[k] && rem_reg[k] != '0) begin
                            rem_reg[k] <= cs_reg - rem_reg[k];
                        end
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (scan_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (func_reg == FUNC_CLEAR) begin
                            count_reg  <= '0;
                            merge_reg  <= '0;
                            m_data_reg <= '0;
                            m_user_reg <= 2'b00;
                        end else if (found_reg) begin
                            merge_reg  <= merge_next;
                            m_data_reg <= M_DATA_W'({merge_next, best_id_out});
                            m_user_reg <= 2'b01;
                        end else if (count_reg >= FULL_CNT) begin
                            m_data_reg <= M_DATA_W'({merge_reg, {ID_W{1'b0}}});
                            m_user_reg <= 2'b10;
                        end else begin
                            count_reg  <= count_reg + 1'b1;
                            m_data_reg <= M_DATA_W'({merge_reg, cnt_id});
                            m_user_reg <= 2'b00;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("stored count beyond table size");

    a_read_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (32'(rd_addr) < 32'(count_reg)))
        else $error("read of an entry not yet stored");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg || v2_reg || v3_reg) |-> !wr_en)
        else $error("table write while scan in flight");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_user_reg[0] && m_user_reg[1]))
        else $error("merged and full both set");

endmodule
